>>> design/lfpg_pkg.sv
// Shared types, codes and constants of the light flicker and pulse generator.
// Used by the interfaces, the entry store and the top level; no dependencies.
package lfpg_pkg;

    localparam int unsigned DEFAULT_TABLE_DEPTH = 64;

    localparam int unsigned FUNC_W     = 2;
    localparam int unsigned KEY_W      = 64;
    localparam int unsigned MODE_W     = 3;
    localparam int unsigned TIME_W     = 48;
    localparam int unsigned LEVEL_W    = 23;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned TICK_W     = 32;
    localparam int unsigned RNG_W      = 31;
    localparam int unsigned SPEED_W    = 17;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 64;

    typedef logic [FUNC_W-1:0]          func_t;
    typedef logic [MODE_W-1:0]          mode_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic signed [LEVEL_W-1:0]  level_t;
    typedef logic [SPEED_W-1:0]         speed_t;

    localparam func_t FN_EVAL  = 2'd0;
    localparam func_t FN_DROP  = 2'd1;
    localparam func_t FN_CLEAR = 2'd2;

    localparam mode_t MD_CONST        = 3'd0;
    localparam mode_t MD_FLICKER      = 3'd1;
    localparam mode_t MD_SLOW_FLICKER = 3'd2;
    localparam mode_t MD_PULSE        = 3'd3;
    localparam mode_t MD_SLOW_PULSE   = 3'd4;

    localparam status_t ST_EXIST = 2'd0;
    localparam status_t ST_NEW   = 2'd1;
    localparam status_t ST_FULL  = 2'd2;
    localparam status_t ST_NONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_EPOCH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT  = 1'd1;

    // Hash and random stream constants.
    localparam logic [63:0] GOLDEN     = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX1       = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX2       = 64'h94d049bb133111eb;
    localparam logic [30:0] MOD_HASH   = 31'd2147483645;
    localparam logic [30:0] MOD_RNG    = 31'd2147483647;
    localparam logic [63:0] RNG_MULT   = 64'd48271;
    localparam logic [63:0] DRAW_SCALE = 64'd786432;
    localparam logic [63:0] DRAW_BIAS  = 64'd1073741822;
    localparam logic [49:0] ROUND_HALF = 50'd32768;

    // Levels in signed Q2.20.
    localparam level_t ONE_Q20     = 23'sd1048576;
    localparam level_t QUARTER_Q20 = 23'sd262144;
    localparam level_t HALF_Q20    = 23'sd524288;
    localparam level_t LEVEL_MAX   = 23'sh3F_FFFF;
    localparam level_t LEVEL_MIN   = 23'sh40_0000;
    localparam level_t LEVEL_ZERO  = 23'sd0;

    localparam speed_t SPEED_FAST = 17'd104858;
    localparam speed_t SPEED_SLOW = 17'd52429;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        mode_t             mode;
        logic              started;
        logic [TIME_W-1:0] seg;
        logic [TIME_W-1:0] el;
        logic [TICK_W-1:0] ticks;
        level_t            lvl;
        level_t            tgt;
        logic [RNG_W-1:0]  rng;
    } entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_one;
        logic clr_all;
    } store_cmd_t;

    function automatic logic is_const(input mode_t m);
        return (m == MD_CONST) || (m > MD_SLOW_PULSE);
    endfunction

    function automatic logic is_flicker(input mode_t m);
        return (m == MD_FLICKER) || (m == MD_SLOW_FLICKER);
    endfunction

    function automatic speed_t speed_of(input mode_t m);
        return ((m == MD_FLICKER) || (m == MD_PULSE)) ? SPEED_FAST : SPEED_SLOW;
    endfunction

endpackage

>>> design/lfpg_ifs.sv
// Channel interfaces of the light flicker and pulse generator: items, results, config.
// Depends on lfpg_pkg for field widths.
interface lfpg_item_if;
    logic                               valid;
    logic                               ready;
    lfpg_pkg::func_t                    func;
    logic [lfpg_pkg::KEY_W-1:0]         light_key;
    lfpg_pkg::mode_t                    mode;
    logic                               time_valid;
    logic [lfpg_pkg::TIME_W-1:0]        sim_time;

    modport source (output valid, func, light_key, mode, time_valid, sim_time, input ready);
    modport sink   (input valid, func, light_key, mode, time_valid, sim_time, output ready);
endinterface

interface lfpg_result_if;
    logic                               valid;
    logic                               ready;
    lfpg_pkg::level_t                   brightness;
    lfpg_pkg::status_t                  status;

    modport source (output valid, brightness, status, input ready);
    modport sink   (input valid, brightness, status, output ready);
endinterface

interface lfpg_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lfpg_pkg::CFG_IDX_W-1:0]     index;
    logic [lfpg_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/lfpg_mul.sv
// Shared 32 by 32 bit multiplier with a registered product.
// Depends on nothing; the sequencer builds wider products from it.
module lfpg_mul
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

>>> design/lfpg_store.sv
// Entry store: one-port-read, one-port-write entry memory plus valid flip-flops.
// Depends on lfpg_pkg for the entry record and the command struct.
module lfpg_store #(
    parameter int unsigned TABLE_DEPTH = lfpg_pkg::DEFAULT_TABLE_DEPTH,
    parameter int unsigned IDX_W       = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lfpg_pkg::store_cmd_t cmd,
    input  logic [IDX_W-1:0]     rd_addr,
    input  logic [IDX_W-1:0]     wr_addr,
    input  lfpg_pkg::entry_t     wr_entry,
    output lfpg_pkg::entry_t     rd_entry,
    output logic                 rd_vld
);

    lfpg_pkg::entry_t       mem [TABLE_DEPTH];
    lfpg_pkg::entry_t       rd_entry_reg;
    logic                   rd_vld_reg;
    logic [TABLE_DEPTH-1:0] vld_reg;

    // Valid bits clear at once on reset and on a whole-table clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_all)
                vld_reg <= '0;
            else if (cmd.clr_one)
                vld_reg[wr_addr] <= 1'b0;
            else if (cmd.wr_en)
                vld_reg[wr_addr] <= 1'b1;
            if (cmd.rd_en)
                rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= wr_entry;
        if (cmd.rd_en)
            rd_entry_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;
    assign rd_vld   = rd_vld_reg;

endmodule

>>> design/light_flicker_pulse_generator.sv
// Light flicker and pulse generator: sequencer, working registers and output word register.
// Depends on lfpg_pkg, lfpg_ifs, lfpg_mul and lfpg_store.
// A constant-mode, clear or unused word goes from idle straight to the output state. An
// evaluate or drop word first sweeps the entry memory one entry per cycle; an evaluate word may
// then seed a new entry, draw a random target and take a ramp step before the output state.
// Throughput: one word at a time; the next word is taken once the current one reaches the
// result register. Reset clears all valid bits at once; no clearing pass is needed.
module light_flicker_pulse_generator #(
    parameter int unsigned TABLE_DEPTH = lfpg_pkg::DEFAULT_TABLE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    lfpg_item_if.sink    item,
    lfpg_result_if.source result,
    lfpg_cfg_if.sink     cfg
);

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    // Sequencer states.
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SRCH  = 5'd1;
    localparam logic [4:0] S_LOOK  = 5'd2;
    localparam logic [4:0] S_HASH0 = 5'd3;
    localparam logic [4:0] S_HASH1 = 5'd4;
    localparam logic [4:0] S_HASH2 = 5'd5;
    localparam logic [4:0] S_HASH3 = 5'd6;
    localparam logic [4:0] S_SEED  = 5'd7;
    localparam logic [4:0] S_DRAW0 = 5'd8;
    localparam logic [4:0] S_DRAW1 = 5'd9;
    localparam logic [4:0] S_DRAW2 = 5'd10;
    localparam logic [4:0] S_DRAW3 = 5'd11;
    localparam logic [4:0] S_DRAW4 = 5'd12;
    localparam logic [4:0] S_TIME  = 5'd13;
    localparam logic [4:0] S_ADV0  = 5'd14;
    localparam logic [4:0] S_ADV1  = 5'd15;
    localparam logic [4:0] S_ADV2  = 5'd16;
    localparam logic [4:0] S_ADV3  = 5'd17;
    localparam logic [4:0] S_WB    = 5'd18;
    localparam logic [4:0] S_OUT   = 5'd19;
    localparam logic [4:0] S_MUL   = 5'd20;
    localparam logic [4:0] S_FOLD  = 5'd21;

    // Control state.
    logic [4:0]        state_reg, state_next;
    logic [4:0]        ret_reg, ret_next;
    logic [1:0]        mk_reg, mk_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              chk_vld_reg, chk_vld_next;
    logic              out_vld_reg, out_vld_next;
    logic [63:0]       epoch_reg;
    lfpg_pkg::level_t  init_reg;

    // Captured word and working registers.
    lfpg_pkg::func_t             func_reg, func_next;
    logic [63:0]                 key_reg, key_next;
    lfpg_pkg::mode_t             mode_reg, mode_next;
    logic                        tvalid_reg, tvalid_next;
    logic [lfpg_pkg::TIME_W-1:0] time_reg, time_next;
    lfpg_pkg::entry_t            wk_reg, wk_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [IDX_W-1:0]            chk_addr_reg, chk_addr_next;
    logic [IDX_W-1:0]            free_idx_reg, free_idx_next;
    logic                        free_found_reg, free_found_next;
    logic                        hit_reg, hit_next;
    logic [63:0]                 op_a_reg, op_a_next;
    logic [63:0]                 op_b_reg, op_b_next;
    logic [63:0]                 mres_reg, mres_next;
    logic [63:0]                 x_reg, x_next;
    logic [33:0]                 q_reg, q_next;
    logic                        c3_reg, c3_next;
    logic                        draw_adv_reg, draw_adv_next;
    lfpg_pkg::status_t           status_reg, status_next;
    lfpg_pkg::level_t            res_reg, res_next;
    lfpg_pkg::level_t            out_bright_reg, out_bright_next;
    lfpg_pkg::status_t           out_status_reg, out_status_next;

    // Store and multiplier connections.
    lfpg_pkg::store_cmd_t cmd;
    lfpg_pkg::entry_t     rd_entry;
    logic                 rd_vld;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_p;

    // Datapath helpers.
    logic [63:0]          hx1, hx1s, hx2, hx3;
    logic [32:0]          fold_hi;
    logic [30:0]          fold_lo;
    logic [30:0]          fold_mod;
    logic [34:0]          fold_hi3;
    logic [35:0]          fold_new;
    logic [48:0]          seg_el;
    logic                 backward;
    logic [51:0]          d15;
    logic [33:0]          ticks3;
    logic [52:0]          tick_sum;
    logic [31:0]          tk_sat;
    logic [49:0]          step_sum;
    logic [33:0]          step;
    logic signed [34:0]   lv_ext, lv_new;
    lfpg_pkg::level_t     lv_sat;
    logic signed [23:0]   diff;
    logic [23:0]          diff_abs;
    lfpg_pkg::speed_t     speed;
    logic                 near;

    lfpg_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    lfpg_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_addr  (cnt_reg[IDX_W-1:0]),
        .wr_addr  (idx_reg),
        .wr_entry (wk_reg),
        .rd_entry (rd_entry),
        .rd_vld   (rd_vld)
    );

    // A 64-bit product modulo 2^64 is built from three 32-bit partial products:
    // low by low, low by high, high by low. The sub-step counter picks the halves.
    assign mul_a = (mk_reg == 2'd2) ? op_a_reg[63:32] : op_a_reg[31:0];
    assign mul_b = (mk_reg == 2'd1) ? op_b_reg[63:32] : op_b_reg[31:0];

    // SplitMix64 xor-shift steps.
    assign hx1  = key_reg ^ mres_reg;
    assign hx1s = hx1 ^ (hx1 >> 30);
    assign hx2  = mres_reg ^ (mres_reg >> 27);
    assign hx3  = mres_reg ^ (mres_reg >> 31);

    // One fold toward a residue modulo 2^31 - c, with c being 1 or 3. The high part
    // counts as quotient, and c times it joins the low part.
    assign fold_hi  = x_reg[63:31];
    assign fold_lo  = x_reg[30:0];
    assign fold_mod = c3_reg ? lfpg_pkg::MOD_HASH : lfpg_pkg::MOD_RNG;
    assign fold_hi3 = c3_reg ? ({2'b0, fold_hi} + {1'b0, fold_hi, 1'b0}) : {2'b0, fold_hi};
    assign fold_new = {1'b0, fold_hi3} + {5'b0, fold_lo};

    // Time bookkeeping.
    assign seg_el   = {1'b0, wk_reg.seg} + {1'b0, wk_reg.el};
    assign backward = ({1'b0, time_reg} < seg_el);
    assign d15      = {x_reg[47:0], 4'b0} - {4'b0, x_reg[47:0]};
    assign ticks3   = {1'b0, wk_reg.ticks, 1'b0} + {2'b0, wk_reg.ticks};
    assign tick_sum = {1'b0, x_reg[51:0]} + {19'b0, ticks3} + 53'd2;
    assign tk_sat   = (|tick_sum[52:34]) ? 32'hFFFF_FFFF : tick_sum[33:2];

    // Ramp step, rounded half up, and the saturated new level.
    assign speed    = lfpg_pkg::speed_of(mode_reg);
    assign step_sum = mres_reg[49:0] + lfpg_pkg::ROUND_HALF;
    assign step     = step_sum[49:16];
    assign lv_ext   = {{12{wk_reg.lvl[22]}}, wk_reg.lvl};
    assign lv_new   = (wk_reg.lvl >= wk_reg.tgt) ? (lv_ext - $signed({1'b0, step}))
                                                  : (lv_ext + $signed({1'b0, step}));
    assign lv_sat   = (lv_new[34:22] == {13{lv_new[34]}}) ? lv_new[22:0]
                    : (lv_new[34] ? lfpg_pkg::LEVEL_MIN : lfpg_pkg::LEVEL_MAX);

    // Distance to target after the step decides whether a new target is due.
    assign diff     = {wk_reg.lvl[22], wk_reg.lvl} - {wk_reg.tgt[22], wk_reg.tgt};
    assign diff_abs = diff[23] ? (24'd0 - diff) : diff;
    assign near     = (diff_abs < {7'b0, speed});

    assign item.ready        = (state_reg == S_IDLE);
    assign result.valid      = out_vld_reg;
    assign result.brightness = out_bright_reg;
    assign result.status     = out_status_reg;
    assign cfg.ready         = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        mk_next         = mk_reg;
        cnt_next        = cnt_reg;
        chk_vld_next    = chk_vld_reg;
        out_vld_next    = out_vld_reg && !result.ready;
        func_next       = func_reg;
        key_next        = key_reg;
        mode_next       = mode_reg;
        tvalid_next     = tvalid_reg;
        time_next       = time_reg;
        wk_next         = wk_reg;
        idx_next        = idx_reg;
        chk_addr_next   = chk_addr_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        hit_next        = hit_reg;
        op_a_next       = op_a_reg;
        op_b_next       = op_b_reg;
        mres_next       = mres_reg;
        x_next          = x_reg;
        q_next          = q_reg;
        c3_next         = c3_reg;
        draw_adv_next   = draw_adv_reg;
        status_next     = status_reg;
        res_next        = res_reg;
        out_bright_next = out_bright_reg;
        out_status_next = out_status_reg;
        cmd             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    func_next   = item.func;
                    key_next    = item.light_key;
                    mode_next   = item.mode;
                    tvalid_next = item.time_valid;
                    time_next   = item.sim_time;
                    status_next = lfpg_pkg::ST_NONE;
                    if (item.func == lfpg_pkg::FN_DROP ||
                        (item.func == lfpg_pkg::FN_EVAL && !lfpg_pkg::is_const(item.mode)))
                    begin
                        cnt_next        = '0;
                        chk_vld_next    = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = S_SRCH;
                    end
                    else
                    begin
                        res_next   = (item.func == lfpg_pkg::FN_EVAL) ? lfpg_pkg::ONE_Q20
                                                                      : lfpg_pkg::LEVEL_ZERO;
                        cmd.clr_all = (item.func == lfpg_pkg::FN_CLEAR);
                        state_next = S_OUT;
                    end
                end
            end

            S_SRCH:
            begin
                // Reads are issued back to back; each check sees the word read in the previous cycle.
                if (chk_vld_reg && rd_vld && rd_entry.key == key_reg)
                begin
                    wk_next      = rd_entry;
                    idx_next     = chk_addr_reg;
                    hit_next     = 1'b1;
                    chk_vld_next = 1'b0;
                    state_next   = S_LOOK;
                end
                else
                begin
                    if (chk_vld_reg && !rd_vld && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_addr_reg;
                    end
                    if (cnt_reg < CNT_W'(TABLE_DEPTH))
                    begin
                        cmd.rd_en     = 1'b1;
                        chk_addr_next = cnt_reg[IDX_W-1:0];
                        chk_vld_next  = 1'b1;
                        cnt_next      = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        chk_vld_next = 1'b0;
                        if (!chk_vld_reg)
                        begin
                            hit_next   = 1'b0;
                            state_next = S_LOOK;
                        end
                    end
                end
            end

            S_LOOK:
            begin
                if (func_reg == lfpg_pkg::FN_DROP)
                begin
                    cmd.clr_one = hit_reg;
                    res_next    = lfpg_pkg::LEVEL_ZERO;
                    state_next  = S_OUT;
                end
                else if (hit_reg && wk_reg.mode == mode_reg)
                begin
                    status_next = lfpg_pkg::ST_EXIST;
                    state_next  = S_TIME;
                end
                else if (hit_reg || free_found_reg)
                begin
                    if (!hit_reg)
                        idx_next = free_idx_reg;
                    status_next     = lfpg_pkg::ST_NEW;
                    wk_next.key     = key_reg;
                    wk_next.mode    = mode_reg;
                    wk_next.started = 1'b0;
                    wk_next.seg     = '0;
                    wk_next.el      = '0;
                    wk_next.ticks   = '0;
                    wk_next.lvl     = init_reg;
                    state_next      = S_HASH0;
                end
                else
                begin
                    status_next = lfpg_pkg::ST_FULL;
                    res_next    = lfpg_pkg::ONE_Q20;
                    state_next  = S_OUT;
                end
            end

            S_HASH0:
            begin
                op_a_next  = epoch_reg;
                op_b_next  = lfpg_pkg::GOLDEN;
                ret_next   = S_HASH1;
                mk_next    = 2'd0;
                state_next = S_MUL;
            end

            S_HASH1:
            begin
                op_a_next  = hx1s;
                op_b_next  = lfpg_pkg::MIX1;
                ret_next   = S_HASH2;
                mk_next    = 2'd0;
                state_next = S_MUL;
            end

            S_HASH2:
            begin
                op_a_next  = hx2;
                op_b_next  = lfpg_pkg::MIX2;
                ret_next   = S_HASH3;
                mk_next    = 2'd0;
                state_next = S_MUL;
            end

            S_HASH3:
            begin
                x_next     = hx3;
                q_next     = '0;
                c3_next    = 1'b1;
                ret_next   = S_SEED;
                state_next = S_FOLD;
            end

            S_SEED:
            begin
                wk_next.rng   = x_reg[30:0] + 31'd1;
                draw_adv_next = 1'b0;
                state_next    = S_DRAW0;
            end

            S_DRAW0:
            begin
                op_a_next  = {33'b0, wk_reg.rng};
                op_b_next  = lfpg_pkg::RNG_MULT;
                ret_next   = S_DRAW1;
                mk_next    = 2'd0;
                state_next = S_MUL;
            end

            S_DRAW1:
            begin
                x_next     = mres_reg;
                q_next     = '0;
                c3_next    = 1'b0;
                ret_next   = S_DRAW2;
                state_next = S_FOLD;
            end

            S_DRAW2:
            begin
                wk_next.rng = x_reg[30:0];
                op_a_next   = (x_reg[30:0] == 31'd0) ? 64'd0 : {33'b0, x_reg[30:0] - 31'd1};
                op_b_next   = lfpg_pkg::DRAW_SCALE;
                ret_next    = S_DRAW3;
                mk_next     = 2'd0;
                state_next  = S_MUL;
            end

            S_DRAW3:
            begin
                x_next     = mres_reg + lfpg_pkg::DRAW_BIAS;
                q_next     = '0;
                c3_next    = 1'b1;
                ret_next   = S_DRAW4;
                state_next = S_FOLD;
            end

            S_DRAW4:
            begin
                wk_next.tgt = lfpg_pkg::QUARTER_Q20 + lfpg_pkg::LEVEL_W'(q_reg);
                state_next  = draw_adv_reg ? S_WB : S_TIME;
            end

            S_TIME:
            begin
                if (!tvalid_reg)
                    state_next = S_WB;
                else if (!wk_reg.started || backward)
                begin
                    // First valid time, or time went backward: a new segment starts here.
                    wk_next.started = 1'b1;
                    wk_next.seg     = time_reg;
                    wk_next.el      = '0;
                    wk_next.ticks   = '0;
                    state_next      = S_WB;
                end
                else
                begin
                    x_next     = {16'b0, time_reg - seg_el[47:0]};
                    state_next = S_ADV0;
                end
            end

            S_ADV0:
            begin
                x_next     = {12'b0, d15};
                state_next = S_ADV1;
            end

            S_ADV1:
            begin
                wk_next.ticks = tk_sat;
                wk_next.el    = time_reg - wk_reg.seg;
                op_a_next     = {32'b0, tk_sat};
                op_b_next     = {47'b0, speed};
                ret_next      = S_ADV2;
                mk_next       = 2'd0;
                state_next    = S_MUL;
            end

            S_ADV2:
            begin
                wk_next.lvl = lv_sat;
                state_next  = S_ADV3;
            end

            S_ADV3:
            begin
                if (near && lfpg_pkg::is_flicker(mode_reg))
                begin
                    draw_adv_next = 1'b1;
                    state_next    = S_DRAW0;
                end
                else
                begin
                    if (near)
                        wk_next.tgt = (wk_reg.tgt <= lfpg_pkg::HALF_Q20) ? lfpg_pkg::ONE_Q20
                                                                        : lfpg_pkg::QUARTER_Q20;
                    state_next = S_WB;
                end
            end

            S_WB:
            begin
                cmd.wr_en  = 1'b1;
                res_next   = wk_reg.lvl;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_vld_reg || result.ready)
                begin
                    out_bright_next = res_reg;
                    out_status_next = status_reg;
                    out_vld_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_MUL:
            begin
                unique case (mk_reg)
                    2'd0:
                    begin
                        mk_next = 2'd1;
                    end
                    2'd1:
                    begin
                        mres_next = mul_p;
                        mk_next   = 2'd2;
                    end
                    2'd2:
                    begin
                        mres_next = mres_reg + {mul_p[31:0], 32'b0};
                        mk_next   = 2'd3;
                    end
                    2'd3:
                    begin
                        mres_next  = mres_reg + {mul_p[31:0], 32'b0};
                        mk_next    = 2'd0;
                        state_next = ret_reg;
                    end
                    default:
                    begin
                        mk_next = 2'd0;
                    end
                endcase
            end

            S_FOLD:
            begin
                if (fold_hi != 33'd0)
                begin
                    x_next = {28'b0, fold_new};
                    q_next = q_reg + {1'b0, fold_hi};
                end
                else
                begin
                    // Below 2^31, so at most one subtraction brings it under the modulus.
                    if (fold_lo >= fold_mod)
                    begin
                        x_next = {33'b0, fold_lo - fold_mod};
                        q_next = q_reg + 34'd1;
                    end
                    state_next = ret_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            mk_reg      <= 2'd0;
            cnt_reg     <= '0;
            chk_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            epoch_reg   <= '0;
            init_reg    <= lfpg_pkg::LEVEL_ZERO;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            mk_reg      <= mk_next;
            cnt_reg     <= cnt_next;
            chk_vld_reg <= chk_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg.valid)
            begin
                if (cfg.index == lfpg_pkg::CFG_EPOCH)
                    epoch_reg <= cfg.data;
                else if (cfg.index == lfpg_pkg::CFG_INIT)
                    init_reg <= cfg.data[lfpg_pkg::LEVEL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        mode_reg       <= mode_next;
        tvalid_reg     <= tvalid_next;
        time_reg       <= time_next;
        wk_reg         <= wk_next;
        idx_reg        <= idx_next;
        chk_addr_reg   <= chk_addr_next;
        free_idx_reg   <= free_idx_next;
        free_found_reg <= free_found_next;
        hit_reg        <= hit_next;
        op_a_reg       <= op_a_next;
        op_b_reg       <= op_b_next;
        mres_reg       <= mres_next;
        x_reg          <= x_next;
        q_reg          <= q_next;
        c3_reg         <= c3_next;
        draw_adv_reg   <= draw_adv_next;
        status_reg     <= status_next;
        res_reg        <= res_next;
        out_bright_reg <= out_bright_next;
        out_status_reg <= out_status_next;
    end

    // One word at a time: after a word is taken the input is closed in the next cycle.
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("input open right after taking a word");

    // The partial-product counter only runs inside the multiply sequence.
    a_mul_step: assert property (@(posedge clk) disable iff (!rst_n)
        (mk_reg != 2'd0) |-> (state_reg == S_MUL))
        else $error("multiply step counter active outside multiply");

    // The seed residue is fully reduced before it becomes the stream state.
    a_seed_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEED) |-> (x_reg < {33'b0, lfpg_pkg::MOD_HASH}))
        else $error("seed residue not reduced");

    // The sweep never runs past the table.
    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH) |-> (cnt_reg <= CNT_W'(TABLE_DEPTH)))
        else $error("search sweep beyond table depth");

    // Only an evaluated entry is written back, with a hit or new-entry status.
    a_wb_status: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (status_reg == lfpg_pkg::ST_NEW || status_reg == lfpg_pkg::ST_EXIST))
        else $error("entry written with a wrong status");

endmodule

>>> sim/light_flicker_pulse_generator_tb.sv
// Self-checking testbench for light_flicker_pulse_generator: directed and random words,
// predicted in-line and compared result by result. Depends on lfpg_pkg and lfpg_ifs.
module light_flicker_pulse_generator_tb;

    localparam int DEPTH      = 64;
    localparam int KEY_POOL   = 24;
    localparam int SETTLE     = 200;       // longest word latency, with margin
    localparam int IDLE_LIMIT = 20000;     // cycles with no handshake before giving up
    localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;
    localparam lfpg_pkg::func_t FN_UNUSED = 2'd3;

    typedef struct packed {
        lfpg_pkg::level_t  brightness;
        lfpg_pkg::status_t status;
    } light_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lfpg_item_if   item ();
    lfpg_result_if result ();
    lfpg_cfg_if    cfg ();

    light_flicker_pulse_generator #(.TABLE_DEPTH(DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    always #10 clk = ~clk;

    // Our own copy of the light table and the two configuration registers.
    logic [63:0]      epoch_reg;
    lfpg_pkg::level_t init_level_reg;
    logic             tbl_valid [DEPTH];
    logic [63:0]      tbl_key [DEPTH];
    lfpg_pkg::mode_t  tbl_mode [DEPTH];
    logic             tbl_started [DEPTH];
    logic [63:0]      tbl_seg [DEPTH];
    logic [63:0]      tbl_elapsed [DEPTH];
    logic [31:0]      tbl_ticks [DEPTH];
    longint           tbl_level [DEPTH];
    longint           tbl_target [DEPTH];
    logic [63:0]      tbl_rng [DEPTH];

    light_result_t pending_results [$];
    int  error_count = 0;
    int  idle_cycles = 0;
    int  hold_off_cycles = 0;   // a long receiver hold-off, counted down by the receiver

    // Stimulus bookkeeping for the random part: a pool of lights with their own clocks.
    logic [63:0]     light_keys [KEY_POOL];
    logic [47:0]     light_clock [KEY_POOL];
    lfpg_pkg::mode_t light_mode [KEY_POOL];
    int burst_left = 0;

    // SplitMix64 hash of the key and epoch, folded into [1, 2^31-3], inside the minstd range.
    function automatic logic [63:0] seed_for_key(input logic [63:0] key);
        logic [63:0] h;
        h = key ^ (epoch_reg * lfpg_pkg::GOLDEN);
        h = (h ^ (h >> 30)) * lfpg_pkg::MIX1;
        h = (h ^ (h >> 27)) * lfpg_pkg::MIX2;
        h = h ^ (h >> 31);
        return (h % 64'd2147483645) + 64'd1;
    endfunction

    // One minstd step on the entry's stream, mapped to a target in [0.25, 1.0].
    function automatic longint draw_flicker_target(input int i);
        logic [63:0] s;
        logic [63:0] p;
        s = (tbl_rng[i] * lfpg_pkg::RNG_MULT) % 64'd2147483647;
        tbl_rng[i] = s;
        p = (s == 64'd0) ? 64'd0 : s - 64'd1;
        return longint'(lfpg_pkg::QUARTER_Q20)
             + longint'((p * lfpg_pkg::DRAW_SCALE + lfpg_pkg::DRAW_BIAS) / 64'd2147483645);
    endfunction

    // Works out the result of one word and updates the table copy.
    function automatic light_result_t predict_brightness(input lfpg_pkg::func_t fn,
                                                         input logic [63:0] key,
                                                         input lfpg_pkg::mode_t md,
                                                         input logic tvalid,
                                                         input logic [47:0] t);
        light_result_t r;
        int hit;
        int free_slot;
        logic [63:0] d;
        logic [63:0] tk;
        longint spd;
        longint stp;
        longint lv;
        longint tg;
        longint diff;
        hit = -1;
        free_slot = -1;
        r.status = lfpg_pkg::ST_EXIST;
        if (fn != lfpg_pkg::FN_EVAL)
        begin
            for (int i = 0; i < DEPTH; i++)
                if (fn == lfpg_pkg::FN_CLEAR ||
                    (fn == lfpg_pkg::FN_DROP && tbl_valid[i] && tbl_key[i] == key))
                    tbl_valid[i] = 1'b0;
            r.brightness = lfpg_pkg::LEVEL_ZERO;
            r.status = lfpg_pkg::ST_NONE;
            return r;
        end
        if (md == lfpg_pkg::MD_CONST || md > lfpg_pkg::MD_SLOW_PULSE)
        begin
            r.brightness = lfpg_pkg::ONE_Q20;
            r.status = lfpg_pkg::ST_NONE;
            return r;
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == key)
                hit = i;
            if (hit < 0 && !tbl_valid[i] && free_slot < 0)
                free_slot = i;
        end
        if (hit < 0)
        begin
            if (free_slot < 0)
            begin
                r.brightness = lfpg_pkg::ONE_Q20;
                r.status = lfpg_pkg::ST_FULL;
                return r;
            end
            hit = free_slot;
            tbl_valid[hit] = 1'b1;
            tbl_key[hit] = key;
            r.status = lfpg_pkg::ST_NEW;
        end
        else if (tbl_mode[hit] != md)
        begin
            r.status = lfpg_pkg::ST_NEW;
        end
        if (r.status == lfpg_pkg::ST_NEW)
        begin
            tbl_mode[hit] = md;
            tbl_started[hit] = 1'b0;
            tbl_seg[hit] = 64'd0;
            tbl_elapsed[hit] = 64'd0;
            tbl_ticks[hit] = 32'd0;
            tbl_level[hit] = longint'(init_level_reg);
            tbl_rng[hit] = seed_for_key(key);
            tbl_target[hit] = draw_flicker_target(hit);
        end
        if (tvalid)
        begin
            if (!tbl_started[hit] || {16'd0, t} < tbl_seg[hit] + tbl_elapsed[hit])
            begin
                // First usable time, or time ran backward: the segment starts over.
                tbl_started[hit] = 1'b1;
                tbl_seg[hit] = {16'd0, t};
                tbl_elapsed[hit] = 64'd0;
                tbl_ticks[hit] = 32'd0;
            end
            else
            begin
                d = {16'd0, t} - tbl_seg[hit] - tbl_elapsed[hit];
                tk = (d * 64'd15 + {32'd0, tbl_ticks[hit]} * 64'd3 + 64'd2) >> 2;
                if (tk > 64'hFFFF_FFFF)
                    tk = 64'hFFFF_FFFF;
                tbl_ticks[hit] = tk[31:0];
                tbl_elapsed[hit] = ({16'd0, t} - tbl_seg[hit]) & {16'd0, MASK48};
                spd = longint'(lfpg_pkg::speed_of(md));
                stp = longint'((tk * 64'(lfpg_pkg::speed_of(md)) + 64'd32768) >> 16);
                lv = tbl_level[hit];
                tg = tbl_target[hit];
                lv = (lv >= tg) ? lv - stp : lv + stp;
                if (lv > longint'(lfpg_pkg::LEVEL_MAX))
                    lv = longint'(lfpg_pkg::LEVEL_MAX);
                if (lv < longint'(lfpg_pkg::LEVEL_MIN))
                    lv = longint'(lfpg_pkg::LEVEL_MIN);
                tbl_level[hit] = lv;
                diff = (lv < tg) ? tg - lv : lv - tg;
                if (diff < spd)
                begin
                    if (lfpg_pkg::is_flicker(md))
                        tbl_target[hit] = draw_flicker_target(hit);
                    else
                        tbl_target[hit] = (tg <= longint'(lfpg_pkg::HALF_Q20))
                                        ? longint'(lfpg_pkg::ONE_Q20)
                                        : longint'(lfpg_pkg::QUARTER_Q20);
                end
            end
        end
        r.brightness = lfpg_pkg::level_t'(tbl_level[hit]);
        return r;
    endfunction

    // Writes one configuration register; only called while the block is idle.
    task automatic write_register(input logic [lfpg_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [63:0] value);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data = value;
        do @(posedge clk); while (!cfg.ready);
        if (idx == lfpg_pkg::CFG_EPOCH)
            epoch_reg = value;
        else
            init_level_reg = lfpg_pkg::level_t'(value[lfpg_pkg::LEVEL_W-1:0]);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // Sends one word, records its expected result, then maybe leaves a gap.
    task automatic send_word(input lfpg_pkg::func_t fn, input logic [63:0] key,
                             input lfpg_pkg::mode_t md, input logic tvalid,
                             input logic [47:0] t);
        int gap;
        item.valid = 1'b1;
        item.func = fn;
        item.light_key = key;
        item.mode = md;
        item.time_valid = tvalid;
        item.sim_time = t;
        do @(posedge clk); while (!item.ready);
        pending_results.insert(pending_results.size(),
                               predict_brightness(fn, key, md, tvalid, t));
        @(negedge clk);
        item.valid = 1'b0;
        // Bursts of back-to-back words with random gaps between them.
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            repeat (gap) @(negedge clk);
        end
    endtask

    // Waits until every expected word has come back, plus the block's settling time.
    task automatic drain_results();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Directed part: extremes of fields, every function and mode, and the special cases.
    task automatic test_directed();
        logic [63:0] k;
        k = 64'hFFFF_FFFF_FFFF_FFFF;
        send_word(lfpg_pkg::FN_EVAL, k, lfpg_pkg::MD_CONST, 1'b1, 48'd0);   // constant mode
        send_word(lfpg_pkg::FN_EVAL, k, 3'd7, 1'b1, MASK48);        // high modes are constant
        send_word(lfpg_pkg::FN_EVAL, k, lfpg_pkg::MD_FLICKER, 1'b0, 48'd0);  // no usable time
        send_word(lfpg_pkg::FN_EVAL, k, lfpg_pkg::MD_FLICKER, 1'b1, 48'h0001_0000); // first
        send_word(lfpg_pkg::FN_EVAL, k, lfpg_pkg::MD_FLICKER, 1'b1, 48'h0001_2000); // ramp
        send_word(lfpg_pkg::FN_EVAL, k, lfpg_pkg::MD_FLICKER, 1'b1, 48'h0001_1000); // backward
        send_word(lfpg_pkg::FN_EVAL, k, lfpg_pkg::MD_FLICKER, 1'b0, MASK48); // keeps level
        send_word(lfpg_pkg::FN_EVAL, k, lfpg_pkg::MD_FLICKER, 1'b1, MASK48); // ticks saturate
        send_word(lfpg_pkg::FN_EVAL, k, lfpg_pkg::MD_PULSE, 1'b1, 48'd0);    // mode change
        send_word(lfpg_pkg::FN_EVAL, k, lfpg_pkg::MD_PULSE, 1'b1, 48'h0000_4000);
        send_word(lfpg_pkg::FN_EVAL, 64'd0, lfpg_pkg::MD_SLOW_FLICKER, 1'b1, 48'd5);
        send_word(lfpg_pkg::FN_EVAL, 64'd0, lfpg_pkg::MD_SLOW_FLICKER, 1'b1, 48'h0002_0005);
        send_word(lfpg_pkg::FN_EVAL, 64'd0, lfpg_pkg::MD_SLOW_PULSE, 1'b1, 48'h0002_0005);
        send_word(lfpg_pkg::FN_EVAL, 64'd0, lfpg_pkg::MD_SLOW_PULSE, 1'b1, 48'h0004_0000);
        send_word(lfpg_pkg::FN_DROP, 64'd0, lfpg_pkg::MD_CONST, 1'b0, 48'd0); // present key
        send_word(lfpg_pkg::FN_DROP, 64'd12345, 3'd7, 1'b1, MASK48);          // absent key
        send_word(lfpg_pkg::FN_EVAL, 64'd0, lfpg_pkg::MD_SLOW_PULSE, 1'b1,
                  48'h0005_0000);                                   // key comes back new
        send_word(FN_UNUSED, k, lfpg_pkg::MD_FLICKER, 1'b1, 48'd0);          // unused function
        send_word(lfpg_pkg::FN_CLEAR, k, lfpg_pkg::MD_FLICKER, 1'b1, 48'd0); // clear the table
        send_word(lfpg_pkg::FN_EVAL, k, lfpg_pkg::MD_PULSE, 1'b1, 48'd0);
    endtask

    // Fills every entry and overflows, then frees one entry, reuses it and overflows again.
    task automatic test_table_full();
        for (int i = 0; i < DEPTH; i++)
            send_word(lfpg_pkg::FN_EVAL, {32'(i), 32'hA5A5_0000},
                      lfpg_pkg::mode_t'(1 + i % 4), 1'b1, 48'(i));
        send_word(lfpg_pkg::FN_EVAL, 64'hDEAD_0000_0000_0001, lfpg_pkg::MD_FLICKER, 1'b1, 48'd0);
        send_word(lfpg_pkg::FN_DROP, {32'd17, 32'hA5A5_0000}, lfpg_pkg::MD_CONST, 1'b0, 48'd0);
        send_word(lfpg_pkg::FN_EVAL, 64'hDEAD_0000_0000_0001, lfpg_pkg::MD_FLICKER, 1'b1, 48'd0);
        send_word(lfpg_pkg::FN_EVAL, 64'hDEAD_0000_0000_0002, lfpg_pkg::MD_FLICKER, 1'b1, 48'd0);
        send_word(lfpg_pkg::FN_CLEAR, 64'd0, lfpg_pkg::MD_CONST, 1'b0, 48'd0);
    endtask

    // Random words over a pool of lights; most advance each light's clock a little so the
    // ramps reach their targets, the rest are mode changes, odd times and table commands.
    task automatic test_random_traffic(input int count);
        int              li;
        int              pick;
        lfpg_pkg::func_t fn;
        logic            tvalid;
        logic [47:0]     t;
        for (int n = 0; n < count; n++)
        begin
            li = $urandom_range(0, KEY_POOL - 1);
            pick = $urandom_range(0, 99);
            fn = lfpg_pkg::FN_EVAL;
            if (pick < 4)
                fn = lfpg_pkg::FN_DROP;
            else if (pick < 5)
                fn = lfpg_pkg::FN_CLEAR;
            else if (pick < 6)
                fn = FN_UNUSED;
            if ($urandom_range(0, 9) == 0)
                light_mode[li] = lfpg_pkg::mode_t'($urandom_range(0, 7));
            tvalid = ($urandom_range(0, 15) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 85)
                t = light_clock[li] + 48'($urandom_range(0, 32'h6000));
            else if (pick < 93)
                t = light_clock[li] - 48'($urandom_range(0, 32'h20000));
            else
                t = 48'({$urandom, $urandom});
            if (tvalid)
                light_clock[li] = t;
            send_word(fn, light_keys[li], light_mode[li], tvalid, t);
        end
    endtask

    // The receiver holds off for a long stretch while words keep coming, so the block
    // stalls its input; then the sender waits for every result before going on.
    task automatic test_backpressure();
        hold_off_cycles = 600;
        test_random_traffic(40);
        while (pending_results.size() != 0)
            @(negedge clk);
        test_random_traffic(20);
    endtask

    // Result side: a stall pattern in one of four styles, redrawn at random, including
    // stretches with no stalls at all, plus the long hold-off above.
    int rx_cycle = 0;
    int rx_style = 0;
    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 256 == 0)
            rx_style <= $urandom_range(0, 3);
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            result.ready <= 1'b0;
        end
        else
        begin
            case (rx_style)
                0: result.ready <= 1'b1;
                1: result.ready <= ((rx_cycle % 7) < 4);
                2: result.ready <= ($urandom_range(0, 3) != 0);
                default: result.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Each accepted result word is compared with the oldest expectation.
    always @(posedge clk)
    begin
        light_result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word brightness=%0d status=%0d",
                         $time, result.brightness, result.status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.brightness !== want.brightness)
                begin
                    $display("%0t: brightness expected %0d actual %0d",
                             $time, want.brightness, result.brightness);
                    error_count++;
                end
                if (result.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, result.status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run if no handshake happens for a long time.
    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        item.valid = 1'b0;
        item.func = lfpg_pkg::FN_EVAL;
        item.light_key = 64'd0;
        item.mode = lfpg_pkg::MD_CONST;
        item.time_valid = 1'b0;
        item.sim_time = 48'd0;
        result.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = lfpg_pkg::CFG_EPOCH;
        cfg.data = 64'd0;
        epoch_reg = 64'd0;
        init_level_reg = lfpg_pkg::LEVEL_ZERO;
        for (int i = 0; i < DEPTH; i++)
            tbl_valid[i] = 1'b0;
        for (int i = 0; i < KEY_POOL; i++)
        begin
            light_keys[i] = {$urandom, $urandom};
            light_clock[i] = 48'($urandom_range(0, 32'h10000));
            light_mode[i] = lfpg_pkg::mode_t'($urandom_range(1, 4));
        end
        light_keys[0] = 64'd0;
        light_keys[1] = 64'hFFFF_FFFF_FFFF_FFFF;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset values first, then several register settings including the extremes.
        test_directed();
        drain_results();
        write_register(lfpg_pkg::CFG_EPOCH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_register(lfpg_pkg::CFG_INIT, 64'h0000_0000_0040_0000);   // most negative level
        test_directed();
        test_table_full();
        drain_results();
        write_register(lfpg_pkg::CFG_EPOCH, {$urandom, $urandom});
        write_register(lfpg_pkg::CFG_INIT, 64'hFFFF_FFFF_FF3F_FFFF);   // most positive, junk
        test_random_traffic(500);
        test_backpressure();
        drain_results();
        write_register(lfpg_pkg::CFG_INIT, 64'(lfpg_pkg::ONE_Q20));
        write_register(lfpg_pkg::CFG_EPOCH, 64'd1);
        test_random_traffic(600);
        drain_results();
        write_register(lfpg_pkg::CFG_INIT, {$urandom, $urandom});
        write_register(lfpg_pkg::CFG_EPOCH, {$urandom, $urandom});
        test_random_traffic(500);

        drain_results();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
